/* sv/srr_pkg.sv */
// shared types, constants and lookup functions for the symbol rate ratio calculator
// no dependencies; imported by srr_div_stage and symbol_rate_ratio_calc
package srr_pkg;

    // field widths
    localparam int RATE_W     = 32;
    localparam int CLAMP_W    = 26;
    localparam int DIV_W      = 25;
    localparam int QUO_W      = 25;
    localparam int PLL_W      = 8;
    localparam int NUM_LOW_W  = 2;

    // divider arrangement: quotient bits resolved per stage and stage count
    localparam int STEP_BITS  = 5;
    localparam int DIV_STAGES = QUO_W / STEP_BITS;

    // input register, clamp/select register, then the divider stages
    localparam int LATENCY    = DIV_STAGES + 2;

    // supported rate range and band edges
    localparam logic [RATE_W-1:0] RATE_MIN = 32'd500000;
    localparam logic [RATE_W-1:0] RATE_MAX = 32'd45499500;
    localparam logic [RATE_W-1:0] EDGE_0   = 32'd90999000 / 32'd4;
    localparam logic [RATE_W-1:0] EDGE_1   = 32'd60666000 / 32'd2;
    localparam logic [RATE_W-1:0] EDGE_2   = 32'd80888000 / 32'd2;

    // quarter sampling clocks used as divisors
    localparam logic [DIV_W-1:0] QCLK_45 = DIV_W'(32'd45499500 >> 2);
    localparam logic [DIV_W-1:0] QCLK_60 = DIV_W'(32'd60666000 >> 2);
    localparam logic [DIV_W-1:0] QCLK_80 = DIV_W'(32'd80888000 >> 2);
    localparam logic [DIV_W-1:0] QCLK_90 = DIV_W'(32'd90999000 >> 2);

    // pll setting bytes
    localparam logic [PLL_W-1:0] PLL_45 = 8'h78;
    localparam logic [PLL_W-1:0] PLL_60 = 8'ha5;
    localparam logic [PLL_W-1:0] PLL_80 = 8'h87;
    localparam logic [PLL_W-1:0] PLL_90 = 8'h78;

    // largest ratio (clamped top rate on the fastest clock) and lower bound for top band
    localparam logic [QUO_W-1:0] RATIO_MAX     = QUO_W'(1) << 24;
    localparam logic [QUO_W-1:0] RATIO_TOP_MIN = QUO_W'(1) << 23;

    // sampling clock select codes
    typedef enum logic [1:0] {
        CLK_45 = 2'd0,
        CLK_60 = 2'd1,
        CLK_80 = 2'd2,
        CLK_90 = 2'd3
    } t_clk_sel;

    // one request as it moves through the divider
    typedef struct packed {
        logic                 valid;
        t_clk_sel             code;
        logic [NUM_LOW_W-1:0] num_low;
        logic [DIV_W-1:0]     rem;
        logic [QUO_W-1:0]     quo;
    } t_srr_item;

    // divisor for a clock code
    function automatic logic [DIV_W-1:0] srr_divisor(input t_clk_sel code);
        logic [DIV_W-1:0] d;
        case (code)
            CLK_45:  d = QCLK_45;
            CLK_60:  d = QCLK_60;
            CLK_80:  d = QCLK_80;
            CLK_90:  d = QCLK_90;
            default: d = QCLK_90;
        endcase
        return d;
    endfunction

    // pll byte for a clock code
    function automatic logic [PLL_W-1:0] srr_pll(input t_clk_sel code);
        logic [PLL_W-1:0] p;
        case (code)
            CLK_45:  p = PLL_45;
            CLK_60:  p = PLL_60;
            CLK_80:  p = PLL_80;
            CLK_90:  p = PLL_90;
            default: p = PLL_90;
        endcase
        return p;
    endfunction

endpackage

/* sv/srr_div_stage.sv */
// one stage of the restoring divider: resolves STEP_BITS quotient bits per cycle
// depends on srr_pkg for the request struct and the divisor table
module srr_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  srr_pkg::t_srr_item i_item,
    output srr_pkg::t_srr_item o_item
);
    import srr_pkg::*;

    t_srr_item r_item;
    t_srr_item n_item;

    // compare-subtract steps, numerator low bits shift in from the top
    always_comb begin
        logic [DIV_W-1:0]     d;
        logic [DIV_W-1:0]     rem;
        logic [QUO_W-1:0]     quo;
        logic [NUM_LOW_W-1:0] nb;
        logic [DIV_W:0]       t;
        d   = srr_divisor(i_item.code);
        rem = i_item.rem;
        quo = i_item.quo;
        nb  = i_item.num_low;
        for (int k = 0; k < STEP_BITS; k++) begin
            t = {rem, nb[NUM_LOW_W-1]};
            if (t >= {1'b0, d}) begin
                rem = DIV_W'(t - {1'b0, d});
                quo = {quo[QUO_W-2:0], 1'b1};
            end else begin
                rem = t[DIV_W-1:0];
                quo = {quo[QUO_W-2:0], 1'b0};
            end
            nb = {nb[NUM_LOW_W-2:0], 1'b0};
        end
        n_item         = i_item;
        n_item.rem     = rem;
        n_item.quo     = quo;
        n_item.num_low = nb;
    end

    // stage register, cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

/* sv/symbol_rate_ratio_calc.sv */
// top level of the symbol rate ratio calculator: clamp, clock select, pipelined divider
// depends on srr_pkg and srr_div_stage
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low. The
//   request carries i_symbol_rate. busy is high only while reset is applied and in
//   the cycle after it, so one request can be issued every cycle.
//   Each request yields one result on o_clock_select, o_pll_setting and
//   o_timing_ratio, shown for exactly one cycle with o_valid high. Results come
//   out in request order.
//   A request passes in order through the input register, the clamp and clock
//   select register and the five divider stages.
//   Throughput: one request per cycle. The five divider stages each resolve five
//   quotient bits of the 25-bit ratio with compare-subtract steps, so the
//   divider sets both latency and the pipeline depth.
//   Reset (synchronous, active low) clears all valid bits; requests in flight
//   are dropped and no result appears until new requests arrive.
//   The receiver cannot hold results off, so the pipeline never stalls.
module symbol_rate_ratio_calc (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    input  logic [srr_pkg::RATE_W-1:0] i_symbol_rate,
    output logic                     busy,
    output logic                     o_valid,
    output logic [1:0]               o_clock_select,
    output logic [srr_pkg::PLL_W-1:0] o_pll_setting,
    output logic [srr_pkg::QUO_W-1:0] o_timing_ratio
);
    import srr_pkg::*;

    logic              r_busy;
    logic              r_in_valid;
    logic [RATE_W-1:0] r_rate;
    t_srr_item         r_head;
    t_srr_item         n_head;
    t_srr_item         stage_item [DIV_STAGES+1];
    logic              accept;

    assign busy   = r_busy | ~i_rst_n;
    assign accept = start & ~busy;

    // busy flag held through reset and in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rate <= i_symbol_rate;
        end
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    // clamp the rate and pick the band; band compares work on the raw rate
    always_comb begin
        logic [CLAMP_W-1:0] rate_c;
        t_clk_sel           code;
        if (r_rate > RATE_MAX) begin
            rate_c = RATE_MAX[CLAMP_W-1:0];
        end else if (r_rate < RATE_MIN) begin
            rate_c = RATE_MIN[CLAMP_W-1:0];
        end else begin
            rate_c = r_rate[CLAMP_W-1:0];
        end
        if (r_rate < EDGE_0) begin
            code = CLK_45;
        end else if (r_rate < EDGE_1) begin
            code = CLK_60;
        end else if (r_rate < EDGE_2) begin
            code = CLK_80;
        end else begin
            code = CLK_90;
        end
        n_head.valid   = r_in_valid;
        n_head.code    = code;
        n_head.num_low = rate_c[NUM_LOW_W-1:0];
        n_head.rem     = DIV_W'(rate_c >> NUM_LOW_W);
        n_head.quo     = '0;
    end

    // clamp and select register feeding the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    assign stage_item[0] = r_head;

    // divider stages
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        srr_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (stage_item[s]),
            .o_item  (stage_item[s+1])
        );
    end

    // result ports straight from the last stage register
    assign o_valid        = stage_item[DIV_STAGES].valid;
    assign o_clock_select = stage_item[DIV_STAGES].code;
    assign o_pll_setting  = srr_pll(stage_item[DIV_STAGES].code);
    assign o_timing_ratio = stage_item[DIV_STAGES].quo;

    // every accepted request gives a result once it has passed the input, clamp/select and divider stage registers
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_valid)
        else $error("request produced no result after pipeline latency");

    // no result without a matching request
    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, LATENCY))
        else $error("result without a matching request");

    // ratio never exceeds the top-rate value
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_timing_ratio <= RATIO_MAX))
        else $error("timing ratio above maximum");

    // only the fastest clock can reach bit 24, and it always sits in the upper half
    a_ratio_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_clock_select != CLK_90 && !o_timing_ratio[QUO_W-1]) ||
                     (o_clock_select == CLK_90 && o_timing_ratio >= RATIO_TOP_MIN)))
        else $error("timing ratio inconsistent with clock band");

endmodule
